FILE: rtl/core/pwf_pkg.sv
// Shared types, codes and helpers for the parabolic waypoint follower.
package pwf_pkg;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_ARC, S_NSQ, S_PEAK, S_LIFT_DIV, S_LIFT_WAIT,
    S_WP_MUL, S_WP_DIV, S_WP_WAIT, S_DIFF, S_SQ_MUL, S_SQ_ACC,
    S_ROOT, S_ROOT_WAIT, S_STEP_MUL, S_STEP, S_U_DIV, S_U_WAIT,
    S_MV_MUL, S_MV_ADD, S_R_MUL, S_CAPTURE, S_EMIT
  } state_t;

  // Flight phase codes
  typedef enum logic [1:0] {
    PH_IDLE, PH_TO_PKG, PH_TO_CUS, PH_DONE
  } phase_t;

  // Register map (word index)
  typedef enum logic [1:0] {
    REG_SPEED, REG_RADIUS, REG_PEAK, REG_COUNT
  } reg_addr_t;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Shared unit widths
  localparam int MUL_W  = 33;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 34;
  localparam int SQ_W   = 66;
  localparam int ROOT_W = 34;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  // Clamp a 36-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pwf_in_if.sv
// Input channel: start or tick transactions.
interface pwf_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [23:0]        dt;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] package_x;
  logic signed [31:0] package_y;
  logic signed [31:0] package_z;
  logic signed [31:0] customer_x;
  logic signed [31:0] customer_y;
  logic signed [31:0] customer_z;

  modport source (
    output valid, action, dt, start_x, start_y, start_z,
    package_x, package_y, package_z, customer_x, customer_y, customer_z,
    input ready
  );
  modport sink (
    input valid, action, dt, start_x, start_y, start_z,
    package_x, package_y, package_z, customer_x, customer_y, customer_z,
    output ready
  );
endinterface

FILE: rtl/core/pwf_out_if.sv
// Output channel: position, phase and waypoint after each transaction.
interface pwf_out_if #(parameter int INDEX_BITS = 10);
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    pos_x;
  logic signed [31:0]    pos_y;
  logic signed [31:0]    pos_z;
  logic [1:0]            phase;
  logic [INDEX_BITS-1:0] waypoint;

  modport source (output valid, pos_x, pos_y, pos_z, phase, waypoint, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, phase, waypoint, output ready);
endinterface

FILE: rtl/core/pwf_mul.sv
// Shared unsigned multiplier with registered product.
module pwf_mul (
  input  logic                      clk,
  input  logic [pwf_pkg::MUL_W-1:0] a,
  input  logic [pwf_pkg::MUL_W-1:0] b,
  output logic [2*pwf_pkg::MUL_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: rtl/core/pwf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pwf_div (
  input  logic              clk,
  input  logic              rst,
  input  pwf_pkg::div_req_t req,
  output pwf_pkg::div_rsp_t rsp
);

  logic [pwf_pkg::DIV_NW-1:0] quo;
  logic [pwf_pkg::DIV_DW-1:0] rem;
  logic [pwf_pkg::DIV_DW-1:0] den;
  logic [5:0]                 cnt;
  logic                       busy;
  logic                       done;
  logic [pwf_pkg::DIV_DW:0]   rem_s;
  logic [pwf_pkg::DIV_DW+1:0] diff;
  logic                       qbit;
  logic [pwf_pkg::DIV_DW-1:0] rem_next;

  // trial subtract
  always_comb begin
    rem_s    = {rem, quo[pwf_pkg::DIV_NW-1]};
    diff     = {1'b0, rem_s} - {2'b00, den};
    qbit     = ~diff[pwf_pkg::DIV_DW+1];
    rem_next = qbit ? diff[pwf_pkg::DIV_DW-1:0] : rem_s[pwf_pkg::DIV_DW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[pwf_pkg::DIV_NW-2:0], qbit};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

FILE: rtl/core/pwf_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module pwf_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pwf_pkg::SQ_W-1:0]   rad_in,
  output logic                       done,
  output logic [pwf_pkg::ROOT_W-1:0] root
);

  logic [pwf_pkg::SQ_W-1:0] rad;
  logic [35:0]              rem;
  logic [5:0]               cnt;
  logic                     busy;
  logic [37:0]              rem_s;
  logic [37:0]              trial;
  logic                     ge;

  always_comb begin
    rem_s = {rem, rad[pwf_pkg::SQ_W-1:pwf_pkg::SQ_W-2]};
    trial = {2'b00, root, 2'b01};
    ge    = (rem_s >= trial);
  end

  // control: one step per radicand bit pair
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(pwf_pkg::SQ_W / 2 - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[pwf_pkg::SQ_W-3:0], 2'b00};
      rem  <= ge ? 36'(rem_s - trial) : rem_s[35:0];
      root <= {root[pwf_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/core/parabolic_waypoint_follower_top.sv
// Top level: register port, sequencer and shared arithmetic of the waypoint follower.
//
//  channel  | dir | handshake         | carries
//  in_ch    | in  | valid/ready       | action, dt, start/package/customer points
//  out_ch   | out | valid/ready       | pos_x/y/z, phase, waypoint
//  APB      | in  | psel/penable      | speed, capture_radius, peak_height, point_count
//
// A start, or a tick while idle or delivered, goes from IDLE straight to EMIT; a tick that
// finds the index at or past a shrunk count passes through CHECK first. A moving tick runs
// seven quotients through the bit-serial divider, the 33-step root unit and the multiplies
// and sequencing between them; a tick on its waypoint skips the move and its three
// quotients. One transaction is in work at a time;
// in_ch.ready is high only while the sequencer waits for input. A finished result sits
// in the output register while the next transaction is taken. rst is synchronous.
module parabolic_waypoint_follower_top #(
  parameter int INDEX_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  pwf_in_if.sink      in_ch,
  pwf_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_MAX = (1 << INDEX_BITS) - 1;

  // configuration
  logic [31:0] speed;
  logic [31:0] radius;
  logic [30:0] peak;
  logic [9:0]  pcount;
  logic        cfg_wr;

  // architectural state
  logic signed [31:0]    pos [3];
  logic signed [31:0]    org [3];
  logic signed [31:0]    pkg [3];
  logic signed [31:0]    cus [3];
  logic [INDEX_BITS-1:0] leg_index;
  pwf_pkg::phase_t       leg_phase;

  // work registers
  pwf_pkg::state_t       state;
  pwf_pkg::state_t       state_next;
  logic [1:0]            k;
  logic                  pass;
  logic [23:0]           dt_r;
  logic [31:0]           arc;
  logic [31:0]           nsq;
  logic [30:0]           lift;
  logic signed [31:0]    w [3];
  logic signed [32:0]    d [3];
  logic [65:0]           acc;
  logic [33:0]           len;
  logic [32:0]           step;
  logic [30:0]           umag;

  // output register
  logic                  ov;
  logic signed [31:0]    o_x;
  logic signed [31:0]    o_y;
  logic signed [31:0]    o_z;
  logic [1:0]            o_ph;
  logic [INDEX_BITS-1:0] o_wp;

  // shared units
  logic [pwf_pkg::MUL_W-1:0]   mul_a;
  logic [pwf_pkg::MUL_W-1:0]   mul_b;
  logic [2*pwf_pkg::MUL_W-1:0] mul_p;
  pwf_pkg::div_req_t           div_req;
  pwf_pkg::div_rsp_t           div_rsp;
  logic                        sq_start;
  logic                        sq_done;
  logic [pwf_pkg::ROOT_W-1:0]  sq_root;

  // combinational helpers
  logic                  in_fire;
  logic [INDEX_BITS-1:0] n_eff;
  logic [INDEX_BITS:0]   idx_inc;
  logic signed [31:0]    a_k;
  logic signed [31:0]    b_k;
  logic signed [32:0]    span;
  logic [31:0]           span_mag;
  logic [31:0]           dmag;
  logic signed [33:0]    qs;
  logic signed [33:0]    wsum;
  logic signed [31:0]    w_new;
  logic [34:0]           mvmag;
  logic signed [35:0]    pos_sum;
  logic [32:0]           step_new;

  pwf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  pwf_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  pwf_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad_in(acc), .done(sq_done), .root(sq_root)
  );

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed  <= '0;
      radius <= '0;
      peak   <= 31'd9830400;
      pcount <= 10'd50;
    end else if (cfg_wr) begin
      unique case (pwf_pkg::reg_addr_t'(paddr[3:2]))
        pwf_pkg::REG_SPEED:  speed  <= pwdata;
        pwf_pkg::REG_RADIUS: radius <= pwdata;
        pwf_pkg::REG_PEAK:   peak   <= pwdata[30:0];
        pwf_pkg::REG_COUNT:  pcount <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pwf_pkg::reg_addr_t'(paddr[3:2]))
      pwf_pkg::REG_SPEED:  prdata = speed;
      pwf_pkg::REG_RADIUS: prdata = radius;
      pwf_pkg::REG_PEAK:   prdata = {1'b0, peak};
      pwf_pkg::REG_COUNT:  prdata = {22'd0, pcount};
      default:             prdata = '0;
    endcase
  end

  // effective waypoint count
  always_comb begin
    if (pcount < 10'd2) begin
      n_eff = INDEX_BITS'(2);
    end else if (int'(pcount) > IDX_MAX) begin
      n_eff = INDEX_BITS'(IDX_MAX);
    end else begin
      n_eff = INDEX_BITS'(pcount);
    end
  end

  assign in_fire = in_ch.valid & in_ch.ready;
  assign idx_inc = {1'b0, leg_index} + 1'b1;

  // per-axis datapath
  always_comb begin
    a_k      = (leg_phase == pwf_pkg::PH_TO_PKG) ? org[k] : pkg[k];
    b_k      = (leg_phase == pwf_pkg::PH_TO_PKG) ? pkg[k] : cus[k];
    span     = 33'(b_k) - 33'(a_k);
    span_mag = span[32] ? 32'(-span) : span[31:0];
    dmag     = d[k][32] ? 32'(-d[k]) : d[k][31:0];
    qs       = span[32] ? -$signed({2'b00, div_rsp.quo[31:0]})
                        : $signed({2'b00, div_rsp.quo[31:0]});
    wsum     = 34'(a_k) + qs;
    if (k == 2'd1) begin
      w_new = pwf_pkg::sat32(36'(wsum) + $signed({5'd0, lift}));
    end else begin
      w_new = wsum[31:0];
    end
    mvmag    = mul_p[64:30];
    pos_sum  = d[k][32] ? 36'(pos[k]) - $signed({1'b0, mvmag})
                        : 36'(pos[k]) + $signed({1'b0, mvmag});
    step_new = (mul_p[55:49] != 7'd0) ? '1 : mul_p[48:16];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pwf_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.action == pwf_pkg::ACT_TICK &&
              (leg_phase == pwf_pkg::PH_TO_PKG || leg_phase == pwf_pkg::PH_TO_CUS)) begin
            state_next = pwf_pkg::S_CHECK;
          end else begin
            state_next = pwf_pkg::S_EMIT;
          end
        end
      end
      pwf_pkg::S_CHECK:
        state_next = (leg_index >= n_eff) ? pwf_pkg::S_EMIT : pwf_pkg::S_ARC;
      pwf_pkg::S_ARC:      state_next = pwf_pkg::S_NSQ;
      pwf_pkg::S_NSQ:      state_next = pwf_pkg::S_PEAK;
      pwf_pkg::S_PEAK:     state_next = pwf_pkg::S_LIFT_DIV;
      pwf_pkg::S_LIFT_DIV: state_next = pwf_pkg::S_LIFT_WAIT;
      pwf_pkg::S_LIFT_WAIT:
        if (div_rsp.done) state_next = pwf_pkg::S_WP_MUL;
      pwf_pkg::S_WP_MUL:   state_next = pwf_pkg::S_WP_DIV;
      pwf_pkg::S_WP_DIV:   state_next = pwf_pkg::S_WP_WAIT;
      pwf_pkg::S_WP_WAIT:
        if (div_rsp.done) state_next = (k == 2'd2) ? pwf_pkg::S_DIFF : pwf_pkg::S_WP_MUL;
      pwf_pkg::S_DIFF:     state_next = pwf_pkg::S_SQ_MUL;
      pwf_pkg::S_SQ_MUL:   state_next = pwf_pkg::S_SQ_ACC;
      pwf_pkg::S_SQ_ACC: begin
        if (k != 2'd2) begin
          state_next = pwf_pkg::S_SQ_MUL;
        end else begin
          state_next = pass ? pwf_pkg::S_R_MUL : pwf_pkg::S_ROOT;
        end
      end
      pwf_pkg::S_ROOT:      state_next = pwf_pkg::S_ROOT_WAIT;
      pwf_pkg::S_ROOT_WAIT:
        if (sq_done) state_next = pwf_pkg::S_STEP_MUL;
      pwf_pkg::S_STEP_MUL:  state_next = pwf_pkg::S_STEP;
      pwf_pkg::S_STEP:
        state_next = (len == '0) ? pwf_pkg::S_R_MUL : pwf_pkg::S_U_DIV;
      pwf_pkg::S_U_DIV:     state_next = pwf_pkg::S_U_WAIT;
      pwf_pkg::S_U_WAIT:
        if (div_rsp.done) state_next = pwf_pkg::S_MV_MUL;
      pwf_pkg::S_MV_MUL:    state_next = pwf_pkg::S_MV_ADD;
      pwf_pkg::S_MV_ADD:
        state_next = (k == 2'd2) ? pwf_pkg::S_DIFF : pwf_pkg::S_U_DIV;
      pwf_pkg::S_R_MUL:     state_next = pwf_pkg::S_CAPTURE;
      pwf_pkg::S_CAPTURE:   state_next = pwf_pkg::S_EMIT;
      pwf_pkg::S_EMIT:
        if (!ov || out_ch.ready) state_next = pwf_pkg::S_IDLE;
      default: state_next = pwf_pkg::S_IDLE;
    endcase
  end

  // unit operands and strobes
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    sq_start      = 1'b0;
    unique case (state)
      pwf_pkg::S_ARC: begin
        mul_a = 33'(leg_index);
        mul_b = 33'(n_eff - leg_index);
      end
      pwf_pkg::S_NSQ: begin
        mul_a = 33'(n_eff);
        mul_b = 33'(n_eff);
      end
      pwf_pkg::S_PEAK: begin
        mul_a = 33'(peak);
        mul_b = 33'(arc);
      end
      pwf_pkg::S_LIFT_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = mul_p[63:0];
        div_req.den   = 34'(nsq);
      end
      pwf_pkg::S_WP_MUL: begin
        mul_a = 33'(span_mag);
        mul_b = 33'(leg_index);
      end
      pwf_pkg::S_WP_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = {16'd0, mul_p[47:0]};
        div_req.den   = 34'(n_eff);
      end
      pwf_pkg::S_SQ_MUL: begin
        mul_a = 33'(dmag);
        mul_b = 33'(dmag);
      end
      pwf_pkg::S_ROOT: sq_start = 1'b1;
      pwf_pkg::S_STEP_MUL: begin
        mul_a = 33'(speed);
        mul_b = 33'(dt_r);
      end
      pwf_pkg::S_U_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = {2'b00, dmag, 30'd0};
        div_req.den   = len;
      end
      pwf_pkg::S_MV_MUL: begin
        mul_a = 33'(umag);
        mul_b = step;
      end
      pwf_pkg::S_R_MUL: begin
        mul_a = 33'(radius);
        mul_b = 33'(radius);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pwf_pkg::S_IDLE;
      leg_phase <= pwf_pkg::PH_IDLE;
      leg_index <= '0;
      ov        <= 1'b0;
      k         <= '0;
      pass      <= 1'b0;
    end else begin
      state <= state_next;
      // output valid: load on emit, clear when taken
      if (state == pwf_pkg::S_EMIT && (!ov || out_ch.ready)) begin
        ov <= 1'b1;
      end else if (ov && out_ch.ready) begin
        ov <= 1'b0;
      end
      unique case (state)
        pwf_pkg::S_IDLE: begin
          k    <= '0;
          pass <= 1'b0;
          if (in_fire && in_ch.action == pwf_pkg::ACT_START) begin
            leg_phase <= pwf_pkg::PH_TO_PKG;
            leg_index <= INDEX_BITS'(1);
          end
        end
        pwf_pkg::S_CHECK: begin
          // count shrunk under the current index: close the leg
          if (leg_index >= n_eff) begin
            if (leg_phase == pwf_pkg::PH_TO_PKG) begin
              leg_phase <= pwf_pkg::PH_TO_CUS;
              leg_index <= '0;
            end else begin
              leg_phase <= pwf_pkg::PH_DONE;
            end
          end
        end
        pwf_pkg::S_WP_WAIT:
          if (div_rsp.done) k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        pwf_pkg::S_DIFF: k <= '0;
        pwf_pkg::S_SQ_ACC: if (k != 2'd2) k <= k + 2'd1;
        pwf_pkg::S_STEP: k <= '0;
        pwf_pkg::S_MV_ADD: begin
          if (k == 2'd2) begin
            pass <= 1'b1;
          end else begin
            k <= k + 2'd1;
          end
        end
        pwf_pkg::S_CAPTURE: begin
          if (acc <= {2'b00, mul_p[63:0]}) begin
            if (idx_inc >= {1'b0, n_eff} && leg_phase == pwf_pkg::PH_TO_PKG) begin
              leg_phase <= pwf_pkg::PH_TO_CUS;
              leg_index <= '0;
            end else begin
              leg_index <= idx_inc[INDEX_BITS-1:0];
              if (idx_inc >= {1'b0, n_eff}) leg_phase <= pwf_pkg::PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        org[i] <= '0;
        pkg[i] <= '0;
        cus[i] <= '0;
      end
    end else begin
      unique case (state)
        pwf_pkg::S_IDLE: begin
          if (in_fire) begin
            dt_r <= in_ch.dt;
            if (in_ch.action == pwf_pkg::ACT_START) begin
              org[0] <= in_ch.start_x;    org[1] <= in_ch.start_y;    org[2] <= in_ch.start_z;
              pkg[0] <= in_ch.package_x;  pkg[1] <= in_ch.package_y;  pkg[2] <= in_ch.package_z;
              cus[0] <= in_ch.customer_x; cus[1] <= in_ch.customer_y; cus[2] <= in_ch.customer_z;
              pos[0] <= in_ch.start_x;    pos[1] <= in_ch.start_y;    pos[2] <= in_ch.start_z;
            end
          end
        end
        pwf_pkg::S_NSQ:  arc <= {mul_p[29:0], 2'b00};
        pwf_pkg::S_PEAK: nsq <= mul_p[31:0];
        pwf_pkg::S_LIFT_WAIT: if (div_rsp.done) lift <= div_rsp.quo[30:0];
        pwf_pkg::S_WP_WAIT:   if (div_rsp.done) w[k] <= w_new;
        pwf_pkg::S_DIFF: begin
          acc <= '0;
          for (int i = 0; i < 3; i++) d[i] <= 33'(w[i]) - 33'(pos[i]);
        end
        pwf_pkg::S_SQ_ACC:    acc <= acc + mul_p;
        pwf_pkg::S_ROOT_WAIT: if (sq_done) len <= sq_root;
        pwf_pkg::S_STEP:      step <= step_new;
        pwf_pkg::S_U_WAIT:    if (div_rsp.done) umag <= div_rsp.quo[30:0];
        pwf_pkg::S_MV_ADD:    pos[k] <= pwf_pkg::sat32(pos_sum);
        pwf_pkg::S_EMIT: begin
          if (!ov || out_ch.ready) begin
            o_x  <= pos[0];
            o_y  <= pos[1];
            o_z  <= pos[2];
            o_ph <= leg_phase;
            o_wp <= leg_index;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready     = !rst && (state == pwf_pkg::S_IDLE);
  assign out_ch.valid    = ov;
  assign out_ch.pos_x    = o_x;
  assign out_ch.pos_y    = o_y;
  assign out_ch.pos_z    = o_z;
  assign out_ch.phase    = o_ph;
  assign out_ch.waypoint = o_wp;

  // checks
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    leg_phase == pwf_pkg::PH_IDLE |-> leg_index == '0)
    else $error("index moved while idle");

  a_start_leg: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.action == pwf_pkg::ACT_START |=>
      leg_phase == pwf_pkg::PH_TO_PKG && leg_index == INDEX_BITS'(1))
    else $error("start did not open leg one");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    state == pwf_pkg::S_IDLE && !in_fire |=>
      $stable(pos[0]) && $stable(pos[1]) && $stable(pos[2]))
    else $error("position changed with no transaction");

endmodule
